/* sv/ia_pkg.sv */
// Shared types and constants for the 64-bit integer ALU.
package ia_pkg;

  localparam int DataW     = 64;
  localparam int DivStages = 64;

  localparam logic [DataW-1:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DataW-1:0] MinNeg = 64'h8000_0000_0000_0000;

  typedef enum logic [3:0] {
    OP_AND, OP_OR,  OP_XOR, OP_NOT,
    OP_SHL, OP_SHR, OP_SAR, OP_ADD,
    OP_SUB, OP_MUL, OP_DIV, OP_MOD,
    OP_NEG, OP_EQ,  OP_LT,  OP_LE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [DataW-1:0] other;
    logic             b_zero;
    logic             a_zero;
    logic             a_neg;
    logic             sign_diff;
  } side_t;

endpackage

/* sv/ia_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
module ia_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  vld_in,
  input  ia_pkg::side_t         side_in,
  input  logic [ia_pkg::DataW-1:0] dividend,
  input  logic [ia_pkg::DataW-1:0] divisor,
  output logic                  vld_out,
  output ia_pkg::side_t         side_out,
  output logic [ia_pkg::DataW-1:0] quotient,
  output logic [ia_pkg::DataW-1:0] remainder
);
  import ia_pkg::*;

  logic             vld  [DivStages+1];
  side_t            side [DivStages+1];
  logic [DataW-1:0] rem  [DivStages+1];
  logic [DataW-1:0] quo  [DivStages+1];
  logic [DataW-1:0] dvs  [DivStages+1];

  assign vld[0]  = vld_in;
  assign side[0] = side_in;
  assign rem[0]  = '0;
  assign quo[0]  = dividend;
  assign dvs[0]  = divisor;

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic [DataW:0] trial;
    logic           fit;

    assign trial = {rem[k], quo[k][DataW-1]} - {1'b0, dvs[k]};
    assign fit   = !trial[DataW];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      side[k+1] <= side[k];
      dvs[k+1]  <= dvs[k];
      quo[k+1]  <= {quo[k][DataW-2:0], fit};
      rem[k+1]  <= fit ? trial[DataW-1:0] : {rem[k][DataW-2:0], quo[k][DataW-1]};
    end
  end

  assign vld_out   = vld[DivStages];
  assign side_out  = side[DivStages];
  assign quotient  = quo[DivStages];
  assign remainder = rem[DivStages];

endmodule

/* sv/int64_alu_unit.sv */
// Top level of the pipelined 64-bit integer ALU.
// The result strobe (done) follows an accepted beat through v1, v2, v3, the divider stages and the done register.
// Throughput: one beat per cycle for every opcode; busy stays low.
// The depth is set by the 64-stage bit-per-stage divider that all opcodes pass through.
// Reset (rst, synchronous) clears all valid bits; no result follows a beat dropped by reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module int64_alu_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [3:0]                  op,
  input  logic signed [ia_pkg::DataW-1:0] operand_a,
  input  logic signed [ia_pkg::DataW-1:0] operand_b,
  output logic                        busy,
  output logic                        done,
  output logic signed [ia_pkg::DataW-1:0] result_value
);
  import ia_pkg::*;

  logic             v1, v2, v3;
  op_t              op1, op2;
  logic [DataW-1:0] a1, b1;

  logic [DataW-1:0] simple2, da2, db2, da3, db3, other3;
  logic [63:0]      pp_ll;
  logic [31:0]      pp_lh, pp_hl;
  side_t            side2, side3, div_side;

  logic [DataW-1:0] simple, mag_a, mag_b;
  logic             big, slt;
  logic [5:0]       sh;

  logic             dvld;
  side_t            dside;
  logic [DataW-1:0] dq, dr, final_res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    op1 <= op_t'(op);
    a1  <= operand_a;
    b1  <= operand_b;
  end

  assign big   = |b1[DataW-1:6];
  assign sh    = b1[5:0];
  assign slt   = $signed(a1) < $signed(b1);
  assign mag_a = a1[DataW-1] ? (~a1 + 64'd1) : a1;
  assign mag_b = b1[DataW-1] ? (~b1 + 64'd1) : b1;

  always_comb begin
    unique case (op1)
      OP_AND: simple = a1 & b1;
      OP_OR:  simple = a1 | b1;
      OP_XOR: simple = a1 ^ b1;
      OP_NOT: simple = ~a1;
      OP_SHL: simple = big ? '0 : (a1 << sh);
      OP_SHR: simple = big ? '0 : (a1 >> sh);
      OP_SAR: simple = big ? {DataW{a1[DataW-1]}} : $unsigned($signed(a1) >>> sh);
      OP_ADD: simple = a1 + b1;
      OP_SUB: simple = a1 - b1;
      OP_MUL: simple = '0;
      OP_DIV: simple = '0;
      OP_MOD: simple = '0;
      OP_NEG: simple = ~a1 + 64'd1;
      OP_EQ:  simple = {63'd0, a1 == b1};
      OP_LT:  simple = {63'd0, slt};
      OP_LE:  simple = {63'd0, slt || (a1 == b1)};
    endcase
  end

  always_ff @(posedge clk) begin
    op2              <= op1;
    simple2          <= simple;
    pp_ll            <= 64'(a1[31:0]) * 64'(b1[31:0]);
    pp_lh            <= a1[31:0] * b1[63:32];
    pp_hl            <= a1[63:32] * b1[31:0];
    da2              <= mag_a;
    db2              <= (b1 == '0) ? 64'd1 : mag_b;
    side2.op         <= op1;
    side2.other      <= '0;
    side2.b_zero     <= b1 == '0;
    side2.a_zero     <= a1 == '0;
    side2.a_neg      <= a1[DataW-1];
    side2.sign_diff  <= a1[DataW-1] ^ b1[DataW-1];
  end

  always_ff @(posedge clk) begin
    other3 <= (op2 == OP_MUL) ? (pp_ll + {pp_lh + pp_hl, 32'd0}) : simple2;
    da3    <= da2;
    db3    <= db2;
    side3  <= side2;
  end

  always_comb begin
    div_side       = side3;
    div_side.other = other3;
  end

  ia_div u_div (
    .clk       (clk),
    .rst       (rst),
    .vld_in    (v3),
    .side_in   (div_side),
    .dividend  (da3),
    .divisor   (db3),
    .vld_out   (dvld),
    .side_out  (dside),
    .quotient  (dq),
    .remainder (dr)
  );

  always_comb begin
    priority if (dside.op == OP_DIV) begin
      if (dside.b_zero) begin
        final_res = dside.a_zero ? 64'd1 : (dside.a_neg ? MinNeg : MaxPos);
      end else begin
        final_res = dside.sign_diff ? (~dq + 64'd1) : dq;
      end
    end else if (dside.op == OP_MOD) begin
      final_res = dside.a_neg ? (~dr + 64'd1) : dr;
    end else begin
      final_res = dside.other;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dvld;
    end
  end

  always_ff @(posedge clk) begin
    result_value <= final_res;
  end

endmodule

/* tb/sv/alu_checker.sv */
// Checker for the 64-bit integer ALU: predicts each accepted beat and compares results.
module alu_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic [3:0]                       op,
  input  logic signed [ia_pkg::DataW-1:0]  operand_a,
  input  logic signed [ia_pkg::DataW-1:0]  operand_b,
  input  logic                             done,
  input  logic signed [ia_pkg::DataW-1:0]  result_value,
  output int                               fail_count,
  output int                               pending
);
  import ia_pkg::*;

  logic [DataW-1:0] expected_results[$];

  assign pending = expected_results.size();

  function automatic logic [DataW-1:0] abs64(logic [DataW-1:0] v);
    return v[DataW-1] ? -v : v;
  endfunction

  function automatic logic [DataW-1:0] alu_result(op_t code, logic [DataW-1:0] a,
                                                  logic [DataW-1:0] b);
    logic [DataW-1:0] r;
    logic [6:0] n;
    logic lt;
    n = (b >= 64) ? 7'd64 : b[6:0];
    lt = $signed(a) < $signed(b);
    case (code)
      OP_AND: r = a & b;
      OP_OR:  r = a | b;
      OP_XOR: r = a ^ b;
      OP_NOT: r = ~a;
      OP_SHL: r = (n == 64) ? '0 : a << n;
      OP_SHR: r = (n == 64) ? '0 : a >> n;
      OP_SAR: r = (n == 64) ? {DataW{a[DataW-1]}} : $unsigned($signed(a) >>> n);
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      OP_DIV: begin
        if (b == 0) r = (a == 0) ? 64'd1 : (a[DataW-1] ? MinNeg : MaxPos);
        else begin
          r = abs64(a) / abs64(b);
          if (a[DataW-1] ^ b[DataW-1]) r = -r;
        end
      end
      OP_MOD: begin
        r = abs64(a) % ((b == 0) ? 64'd1 : abs64(b));
        if (a[DataW-1]) r = -r;
      end
      OP_NEG: r = -a;
      OP_EQ:  r = {63'd0, a == b};
      OP_LT:  r = {63'd0, lt};
      default: r = {63'd0, (a == b) || lt};
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", result_value));
        end else begin
          logic [DataW-1:0] want;
          want = expected_results.pop_front();
          if (result_value !== want)
            report_mismatch($sformatf("result_value got %h want %h", result_value, want));
        end
      end
      if (start && !busy)
        expected_results.push_back(alu_result(op_t'(op), operand_a, operand_b));
    end
  end
endmodule

/* tb/sv/testbench.sv */
// Top of the 64-bit integer ALU testbench: clock, reset, stimulus and verdict.
module testbench;
  import ia_pkg::*;

  logic clk, rst, start, busy, done;
  logic [3:0] op;
  logic signed [DataW-1:0] operand_a, operand_b, result_value;
  int fail_count, pending, idle_cycles;

  int64_alu_unit u_dut (.*);

  alu_checker u_check (.clk, .rst, .start, .busy, .op, .operand_a, .operand_b,
                       .done, .result_value, .fail_count, .pending);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1;
    start = 0;
    op = '0;
    operand_a = '0;
    operand_b = '0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return MaxPos;
      1: return MinNeg;
      2: return '0;
      3: return '1;
      4: return 64'd1;
      5: return 64'(signed'($urandom_range(0, 40)) - 20);
      6: return 64'(1) << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_count();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return 64'd64;
      2: return {$urandom, $urandom};
      3: return 64'($urandom_range(65, 300));
      default: return 64'($urandom_range(0, 63));
    endcase
  endfunction

  task automatic send_beat(op_t code, logic [DataW-1:0] a, logic [DataW-1:0] b);
    start <= 1;
    op <= code;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause();
    start <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  initial begin
    logic [DataW-1:0] a_list[6];
    op_t code;
    int burst;
    a_list = '{MaxPos, MinNeg, 64'd0, '1, 64'd1, 64'h0123_4567_89AB_CDEF};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int i = 0; i < 16; i++)
      send_beat(op_t'(i), a_list[i % 6], a_list[(i + 3) % 6]);
    send_beat(OP_DIV, MinNeg, '1);
    send_beat(OP_MOD, MinNeg, '1);
    send_beat(OP_DIV, 64'd0, 64'd0);
    send_beat(OP_DIV, MinNeg, 64'd0);
    send_beat(OP_MOD, -64'd7, 64'd0);
    send_beat(OP_SAR, MinNeg, 64'd64);
    send_beat(OP_SHL, '1, 64'd0);
    send_beat(OP_SHR, '1, MinNeg);
    pause();
    for (int n = 0; n < 400; ) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst; k++, n++) begin
        code = op_t'($urandom_range(0, 15));
        send_beat(code, pick_value(),
                  (code inside {OP_SHL, OP_SHR, OP_SAR}) ? pick_count() : pick_value());
      end
      if ($urandom_range(0, 3) != 0) pause();
    end
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

/* files.f */
sv/ia_pkg.sv
sv/ia_div.sv
sv/int64_alu_unit.sv
tb/sv/alu_checker.sv
tb/sv/testbench.sv
